### sv/vsh_pkg.sv
// shared types and constants for the triangle vertex shader
`default_nettype none
package vsh_pkg;

  localparam int COORD_BITS    = 16;
  localparam int FRACTION_BITS = 15;
  localparam int UNIT_BITS     = 14;
  localparam int VEC_W         = 2 * COORD_BITS + 2;
  localparam int MAG_W         = VEC_W - 1;
  localparam int PRE_W         = 24;
  localparam int SQ_W          = 2 * PRE_W;
  localparam int LEN2_W        = SQ_W + 2;
  localparam int ROOT_W        = LEN2_W / 2;
  localparam int QUO_W         = UNIT_BITS + 1;
  localparam int UNIT_W        = UNIT_BITS + 2;
  localparam int DOT_W         = 2 * UNIT_W;

  localparam logic [COORD_BITS-1:0] LIGHT_RESET   = COORD_BITS'(300);
  localparam logic [COORD_BITS-1:0] CAMERA_RESET  = '0;
  localparam logic [15:0]           AMBIENT_RESET = 16'((2 << FRACTION_BITS) / 5);

  typedef enum logic [2:0] {
    REG_LIGHT_X  = 3'd0,
    REG_LIGHT_Y  = 3'd1,
    REG_LIGHT_Z  = 3'd2,
    REG_CAMERA_X = 3'd3,
    REG_CAMERA_Y = 3'd4,
    REG_CAMERA_Z = 3'd5,
    REG_AMBIENT  = 3'd6
  } cfg_reg_t;

  typedef logic signed [VEC_W-1:0]  comp_t;
  typedef logic signed [UNIT_W-1:0] ucomp_t;

  typedef struct packed {
    comp_t x;
    comp_t y;
    comp_t z;
  } ivec_t;

  typedef struct packed {
    ucomp_t x;
    ucomp_t y;
    ucomp_t z;
  } uvec_t;

  typedef struct packed {
    logic [1:0] vnum;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } tag_t;

endpackage
`default_nettype wire

### sv/vsh_norm.sv
// pipelined vector normalizer: prescale, sum of squares, square root, divide
`default_nettype none
module vsh_norm (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  vsh_pkg::ivec_t in_vec,
  input  vsh_pkg::tag_t in_tag,
  output logic          out_valid,
  output vsh_pkg::uvec_t out_vec,
  output vsh_pkg::tag_t out_tag
);

  localparam int VW  = vsh_pkg::VEC_W;
  localparam int MW  = vsh_pkg::MAG_W;
  localparam int PW  = vsh_pkg::PRE_W;
  localparam int SW  = $clog2(MW - PW + 1);
  localparam int QW  = vsh_pkg::SQ_W;
  localparam int LW  = vsh_pkg::LEN2_W;
  localparam int RTW = vsh_pkg::ROOT_W;
  localparam int RW  = RTW + 2;
  localparam int DW  = RTW + 1;
  localparam int QUW = vsh_pkg::QUO_W;
  localparam int UW  = vsh_pkg::UNIT_W;
  localparam int UB  = vsh_pkg::UNIT_BITS;

  vsh_pkg::comp_t comp [3];
  assign comp[0] = in_vec.x;
  assign comp[1] = in_vec.y;
  assign comp[2] = in_vec.z;

  // stage a: sign and magnitude
  logic          a_vld_r;
  logic [2:0]    a_sgn_r;
  logic [MW-1:0] a_mag_r [3];
  vsh_pkg::tag_t a_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= in_valid;
    end
    for (int i = 0; i < 3; i++) begin
      a_sgn_r[i] <= comp[i][VW-1];
      a_mag_r[i] <= comp[i][VW-1] ? MW'(-comp[i]) : MW'(comp[i]);
    end
    a_tag_r <= in_tag;
  end

  // stage b: prescale so every magnitude fits PW bits
  logic [MW-1:0] m_or;
  logic [SW-1:0] shamt;
  logic          b_vld_r;
  logic [2:0]    b_sgn_r;
  logic [PW-1:0] b_u_r [3];
  vsh_pkg::tag_t b_tag_r;

  always_comb begin
    m_or  = a_mag_r[0] | a_mag_r[1] | a_mag_r[2];
    shamt = '0;
    for (int i = PW; i < MW; i++) begin
      if (m_or[i]) shamt = SW'(i - PW + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else begin
      b_vld_r <= a_vld_r;
    end
    for (int i = 0; i < 3; i++) begin
      b_u_r[i] <= PW'(a_mag_r[i] >> shamt);
    end
    b_sgn_r <= a_sgn_r;
    b_tag_r <= a_tag_r;
  end

  // stage c: squares
  logic          c_vld_r;
  logic [2:0]    c_sgn_r;
  logic [PW-1:0] c_u_r [3];
  logic [QW-1:0] c_sq_r [3];
  vsh_pkg::tag_t c_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else begin
      c_vld_r <= b_vld_r;
    end
    for (int i = 0; i < 3; i++) begin
      c_sq_r[i] <= QW'(b_u_r[i]) * QW'(b_u_r[i]);
      c_u_r[i]  <= b_u_r[i];
    end
    c_sgn_r <= b_sgn_r;
    c_tag_r <= b_tag_r;
  end

  // square root, one result bit per stage
  logic           s_vld_r  [0:RTW];
  logic [LW-1:0]  s_x_r    [0:RTW];
  logic [RW-1:0]  s_rem_r  [0:RTW];
  logic [RTW-1:0] s_root_r [0:RTW];
  logic [PW-1:0]  s_u_r    [0:RTW][3];
  logic [2:0]     s_sgn_r  [0:RTW];
  vsh_pkg::tag_t  s_tag_r  [0:RTW];
  logic [RW-1:0]  s_rem_nxt  [0:RTW-1];
  logic [RTW-1:0] s_root_nxt [0:RTW-1];

  always_comb begin
    logic [RW-1:0] sh;
    logic [RW-1:0] tr;
    for (int j = 0; j < RTW; j++) begin
      sh = {s_rem_r[j][RW-3:0], s_x_r[j][2*(RTW-1-j) +: 2]};
      tr = {s_root_r[j], 2'b01};
      if (sh >= tr) begin
        s_rem_nxt[j]  = sh - tr;
        s_root_nxt[j] = {s_root_r[j][RTW-2:0], 1'b1};
      end else begin
        s_rem_nxt[j]  = sh;
        s_root_nxt[j] = {s_root_r[j][RTW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j <= RTW; j++) s_vld_r[j] <= 1'b0;
    end else begin
      s_vld_r[0] <= c_vld_r;
      for (int j = 0; j < RTW; j++) s_vld_r[j+1] <= s_vld_r[j];
    end
    s_x_r[0]    <= LW'(c_sq_r[0]) + LW'(c_sq_r[1]) + LW'(c_sq_r[2]);
    s_rem_r[0]  <= '0;
    s_root_r[0] <= '0;
    s_u_r[0]    <= c_u_r;
    s_sgn_r[0]  <= c_sgn_r;
    s_tag_r[0]  <= c_tag_r;
    for (int j = 0; j < RTW; j++) begin
      s_x_r[j+1]    <= s_x_r[j];
      s_rem_r[j+1]  <= s_rem_nxt[j];
      s_root_r[j+1] <= s_root_nxt[j];
      s_u_r[j+1]    <= s_u_r[j];
      s_sgn_r[j+1]  <= s_sgn_r[j];
      s_tag_r[j+1]  <= s_tag_r[j];
    end
  end

  // divide u << UB by length, one quotient bit per stage, three lanes
  logic           q_vld_r [0:QUW];
  logic [RTW-1:0] q_len_r [0:QUW];
  logic [DW-1:0]  q_rem_r [0:QUW][3];
  logic [QUW-1:0] q_q_r   [0:QUW][3];
  logic [2:0]     q_lsb_r [0:QUW];
  logic [2:0]     q_sgn_r [0:QUW];
  vsh_pkg::tag_t  q_tag_r [0:QUW];
  logic [DW-1:0]  q_rem_nxt [0:QUW-1][3];
  logic [QUW-1:0] q_q_nxt   [0:QUW-1][3];

  always_comb begin
    logic [DW-1:0] sh;
    logic          nb;
    for (int j = 0; j < QUW; j++) begin
      for (int i = 0; i < 3; i++) begin
        // only the top numerator bit below the initial remainder can be nonzero
        nb = ((QUW - 1 - j) == UB) ? q_lsb_r[j][i] : 1'b0;
        sh = {q_rem_r[j][i][DW-2:0], nb};
        if (sh >= {1'b0, q_len_r[j]}) begin
          q_rem_nxt[j][i] = sh - {1'b0, q_len_r[j]};
          q_q_nxt[j][i]   = {q_q_r[j][i][QUW-2:0], 1'b1};
        end else begin
          q_rem_nxt[j][i] = sh;
          q_q_nxt[j][i]   = {q_q_r[j][i][QUW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j <= QUW; j++) q_vld_r[j] <= 1'b0;
    end else begin
      q_vld_r[0] <= s_vld_r[RTW];
      for (int j = 0; j < QUW; j++) q_vld_r[j+1] <= q_vld_r[j];
    end
    q_len_r[0] <= s_root_r[RTW];
    for (int i = 0; i < 3; i++) begin
      q_rem_r[0][i] <= DW'(s_u_r[RTW][i] >> 1);
      q_q_r[0][i]   <= '0;
      q_lsb_r[0][i] <= s_u_r[RTW][i][0];
    end
    q_sgn_r[0] <= s_sgn_r[RTW];
    q_tag_r[0] <= s_tag_r[RTW];
    for (int j = 0; j < QUW; j++) begin
      q_len_r[j+1] <= q_len_r[j];
      q_rem_r[j+1] <= q_rem_nxt[j];
      q_q_r[j+1]   <= q_q_nxt[j];
      q_lsb_r[j+1] <= q_lsb_r[j];
      q_sgn_r[j+1] <= q_sgn_r[j];
      q_tag_r[j+1] <= q_tag_r[j];
    end
  end

  // output: sign restore, zero length gives zero vector
  vsh_pkg::ucomp_t unit_c [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (q_len_r[QUW] == '0) begin
        unit_c[i] = '0;
      end else if (q_sgn_r[QUW][i]) begin
        unit_c[i] = -vsh_pkg::ucomp_t'({1'b0, q_q_r[QUW][i]});
      end else begin
        unit_c[i] = vsh_pkg::ucomp_t'({1'b0, q_q_r[QUW][i]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= q_vld_r[QUW];
    end
    out_vec <= '{x: unit_c[0], y: unit_c[1], z: unit_c[2]};
    out_tag <= q_tag_r[QUW];
  end

endmodule
`default_nettype wire

### sv/triangle_lambert_vertex_shader_top.sv
// top level: per-vertex diffuse plus ambient shading of one triangle
//
//  channel  ports                      handshake
//  input    start, busy, in_*          word taken when start and not busy
//  result   out_strobe, out_*          one strobe per word, no back pressure
//  config   cfg_valid/ready/index/data write taken when valid and ready
//
// each triangle's three vertex words leave one per cycle on the single result
// port. a new triangle can be taken in the last issue phase of the one before.
// the normalizers hold a 25-stage square root and a 15-stage divide. reset is
// synchronous and empties the pipeline. there is no stall: the pipeline
// advances every cycle.
`default_nettype none
module triangle_lambert_vertex_shader_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_a_x,
  input  logic [15:0] in_a_y,
  input  logic [15:0] in_a_z,
  input  logic [15:0] in_b_x,
  input  logic [15:0] in_b_y,
  input  logic [15:0] in_b_z,
  input  logic [15:0] in_c_x,
  input  logic [15:0] in_c_y,
  input  logic [15:0] in_c_z,
  input  logic [7:0]  in_base_red,
  input  logic [7:0]  in_base_green,
  input  logic [7:0]  in_base_blue,
  output logic        out_strobe,
  output logic [15:0] out_shade_factor,
  output logic [7:0]  out_lit_red,
  output logic [7:0]  out_lit_green,
  output logic [7:0]  out_lit_blue,
  output logic [1:0]  out_vertex_number,
  output logic        out_last_vertex,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int CB = vsh_pkg::COORD_BITS;
  localparam int VW = vsh_pkg::VEC_W;
  localparam int DT = vsh_pkg::DOT_W;
  localparam int FB = vsh_pkg::FRACTION_BITS;
  localparam int FW = FB + 3;

  // configuration registers
  logic signed [CB-1:0] light_r [3];
  logic signed [CB-1:0] cam_r   [3];
  logic [15:0]          ambient_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        light_r[i] <= vsh_pkg::LIGHT_RESET;
        cam_r[i]   <= vsh_pkg::CAMERA_RESET;
      end
      ambient_r <= vsh_pkg::AMBIENT_RESET;
    end else if (cfg_valid) begin
      unique case (vsh_pkg::cfg_reg_t'(cfg_index))
        vsh_pkg::REG_LIGHT_X:  light_r[0] <= cfg_data[CB-1:0];
        vsh_pkg::REG_LIGHT_Y:  light_r[1] <= cfg_data[CB-1:0];
        vsh_pkg::REG_LIGHT_Z:  light_r[2] <= cfg_data[CB-1:0];
        vsh_pkg::REG_CAMERA_X: cam_r[0]   <= cfg_data[CB-1:0];
        vsh_pkg::REG_CAMERA_Y: cam_r[1]   <= cfg_data[CB-1:0];
        vsh_pkg::REG_CAMERA_Z: cam_r[2]   <= cfg_data[CB-1:0];
        vsh_pkg::REG_AMBIENT:  ambient_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // issue sequencer: three phases per triangle
  logic       active_r;
  logic [1:0] ph_r;
  logic       accept;

  assign busy   = active_r && (ph_r != 2'd2);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      ph_r     <= '0;
    end else if (accept) begin
      active_r <= 1'b1;
      ph_r     <= '0;
    end else if (active_r) begin
      if (ph_r == 2'd2) begin
        active_r <= 1'b0;
      end else begin
        ph_r <= ph_r + 2'd1;
      end
    end
  end

  logic signed [CB-1:0] vtx_r [3][3];
  vsh_pkg::tag_t        col_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      vtx_r[0] <= '{in_a_x, in_a_y, in_a_z};
      vtx_r[1] <= '{in_b_x, in_b_y, in_b_z};
      vtx_r[2] <= '{in_c_x, in_c_y, in_c_z};
      col_r    <= '{vnum: 2'd0, red: in_base_red, green: in_base_green,
                    blue: in_base_blue};
    end
  end

  // edge products in phase 0, cross product in phase 1
  logic signed [CB:0]   e1 [3];
  logic signed [CB:0]   e2 [3];
  vsh_pkg::comp_t       prod_r [6];
  vsh_pkg::ivec_t       cross_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e1[i] = (CB+1)'(vtx_r[0][i]) - (CB+1)'(vtx_r[1][i]);
      e2[i] = (CB+1)'(vtx_r[2][i]) - (CB+1)'(vtx_r[1][i]);
    end
    cross_c.x = prod_r[0] - prod_r[1];
    cross_c.y = prod_r[2] - prod_r[3];
    cross_c.z = prod_r[4] - prod_r[5];
  end

  always_ff @(posedge clk) begin
    if (active_r && ph_r == 2'd0) begin
      prod_r[0] <= VW'(e1[1]) * VW'(e2[2]);
      prod_r[1] <= VW'(e1[2]) * VW'(e2[1]);
      prod_r[2] <= VW'(e1[2]) * VW'(e2[0]);
      prod_r[3] <= VW'(e1[0]) * VW'(e2[2]);
      prod_r[4] <= VW'(e1[0]) * VW'(e2[1]);
      prod_r[5] <= VW'(e1[1]) * VW'(e2[0]);
    end
  end

  // normalizer feeds
  logic signed [CB-1:0] vsel [3];
  vsh_pkg::ivec_t       ldir_c, cdir_c, nin_vec;
  vsh_pkg::tag_t        ltag_c, ntag_c;
  logic                 nin_vld;

  always_comb begin
    unique case (ph_r)
      2'd0:    vsel = vtx_r[0];
      2'd1:    vsel = vtx_r[1];
      default: vsel = vtx_r[2];
    endcase
    ldir_c.x = VW'(light_r[0]) - VW'(vsel[0]);
    ldir_c.y = VW'(light_r[1]) - VW'(vsel[1]);
    ldir_c.z = VW'(light_r[2]) - VW'(vsel[2]);
    cdir_c.x = VW'(cam_r[0]) - VW'(vtx_r[0][0]);
    cdir_c.y = VW'(cam_r[1]) - VW'(vtx_r[0][1]);
    cdir_c.z = VW'(cam_r[2]) - VW'(vtx_r[0][2]);
    ltag_c      = col_r;
    ltag_c.vnum = ph_r;
    ntag_c      = col_r;
    ntag_c.vnum = ph_r;
    nin_vld = active_r && (ph_r != 2'd2);
    nin_vec = (ph_r == 2'd0) ? cdir_c : cross_c;
  end

  logic           lu_vld, nu_vld;
  vsh_pkg::uvec_t lu_vec, nu_vec;
  vsh_pkg::tag_t  lu_tag, nu_tag;

  vsh_norm u_light_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (active_r),
    .in_vec    (ldir_c),
    .in_tag    (ltag_c),
    .out_valid (lu_vld),
    .out_vec   (lu_vec),
    .out_tag   (lu_tag)
  );

  vsh_norm u_face_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (nin_vld),
    .in_vec    (nin_vec),
    .in_tag    (ntag_c),
    .out_valid (nu_vld),
    .out_vec   (nu_vec),
    .out_tag   (nu_tag)
  );

  // face normal, flipped toward the camera
  vsh_pkg::uvec_t        camu_r, nrm_r;
  logic signed [DT-1:0]  cdot;

  assign cdot = DT'(camu_r.x) * DT'(nu_vec.x) + DT'(camu_r.y) * DT'(nu_vec.y)
              + DT'(camu_r.z) * DT'(nu_vec.z);

  always_ff @(posedge clk) begin
    if (nu_vld && nu_tag.vnum == 2'd0) begin
      camu_r <= nu_vec;
    end
    if (nu_vld && nu_tag.vnum == 2'd1) begin
      if (cdot < 0) begin
        nrm_r <= '{x: -nu_vec.x, y: -nu_vec.y, z: -nu_vec.z};
      end else begin
        nrm_r <= nu_vec;
      end
    end
  end

  // light vectors pass through the d1 and d2 registers to wait for the normal
  logic           d1_vld_r, d2_vld_r, dot_vld_r, fac_vld_r;
  vsh_pkg::uvec_t d1_vec_r, d2_vec_r;
  vsh_pkg::tag_t  d1_tag_r, d2_tag_r, dot_tag_r, fac_tag_r;
  logic signed [DT-1:0] dot_r;
  logic [15:0]          fac_r;
  logic [DT-1:0]        dpos;
  logic [FW-1:0]        fsum;
  logic [15:0]          fac_nxt;

  always_comb begin
    dpos    = (dot_r < 0) ? '0 : DT'(dot_r);
    fsum    = FW'(dpos >> (2 * vsh_pkg::UNIT_BITS - FB)) + FW'(ambient_r);
    fac_nxt = (fsum > FW'(1 << FB)) ? 16'(1 << FB) : fsum[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_vld_r   <= 1'b0;
      d2_vld_r   <= 1'b0;
      dot_vld_r  <= 1'b0;
      fac_vld_r  <= 1'b0;
      out_strobe <= 1'b0;
    end else begin
      d1_vld_r   <= lu_vld;
      d2_vld_r   <= d1_vld_r;
      dot_vld_r  <= d2_vld_r;
      fac_vld_r  <= dot_vld_r;
      out_strobe <= fac_vld_r;
    end
    d1_vec_r  <= lu_vec;
    d1_tag_r  <= lu_tag;
    d2_vec_r  <= d1_vec_r;
    d2_tag_r  <= d1_tag_r;
    dot_r     <= DT'(d2_vec_r.x) * DT'(nrm_r.x) + DT'(d2_vec_r.y) * DT'(nrm_r.y)
               + DT'(d2_vec_r.z) * DT'(nrm_r.z);
    dot_tag_r <= d2_tag_r;
    fac_r     <= fac_nxt;
    fac_tag_r <= dot_tag_r;
    out_shade_factor  <= fac_r;
    out_lit_red       <= 8'((24'(fac_tag_r.red) * 24'(fac_r)) >> FB);
    out_lit_green     <= 8'((24'(fac_tag_r.green) * 24'(fac_r)) >> FB);
    out_lit_blue      <= 8'((24'(fac_tag_r.blue) * 24'(fac_r)) >> FB);
    out_vertex_number <= fac_tag_r.vnum;
    out_last_vertex   <= (fac_tag_r.vnum == 2'd2);
  end

endmodule
`default_nettype wire
